### src/mbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared constants, types and channel arithmetic for the 2x2 mip downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int MAX_OUT_WIDTH_DEF = 1024;
    localparam int FIFO_DEPTH_DEF    = 4;

    localparam int PIX_W     = 32;
    localparam int CNT_W     = 11;
    localparam int CH_W      = 8;
    localparam int CH_SUM_W  = 9;
    localparam int NUM_CH    = 4;
    localparam int PS_W      = NUM_CH * CH_SUM_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_EMIT  = 1'b1
    } mbd_op_t;

    typedef struct packed {
        mbd_op_t op;
        logic    last;
    } mbd_ctl_t;

    function automatic logic [PS_W-1:0] pair_sums(input logic [PIX_W-1:0] p,
                                                  input logic [PIX_W-1:0] q);
        logic [PS_W-1:0] packed_sum;
        packed_sum = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            packed_sum[ch*CH_SUM_W +: CH_SUM_W] = {1'b0, p[ch*CH_W +: CH_W]}
                                                + {1'b0, q[ch*CH_W +: CH_W]};
        end
        return packed_sum;
    endfunction

    function automatic logic [PIX_W-1:0] quad_average(input logic [PS_W-1:0] lower,
                                                      input logic [PS_W-1:0] upper);
        logic [PIX_W-1:0]    res;
        logic [CH_SUM_W:0]   s;
        res = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            s = {1'b0, lower[ch*CH_SUM_W +: CH_SUM_W]}
              + {1'b0, upper[ch*CH_SUM_W +: CH_SUM_W]};
            res[ch*CH_W +: CH_W] = s[CH_SUM_W:2];
        end
        return res;
    endfunction

endpackage

### src/mbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_front
// Accepts source pixels, tracks the square position and issues pair-sum requests.
// ----------------------------------------------------------------------------
module mbd_front #(
    parameter int MaxOutWidth = mbd_pkg::MAX_OUT_WIDTH_DEF,
    parameter int AddrW       = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbd_pkg::CNT_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mbd_pkg::PIX_W-1:0]      s_tdata,
    output logic                           push,
    output mbd_pkg::mbd_ctl_t              push_ctl,
    output logic [AddrW-1:0]               push_idx,
    output logic [mbd_pkg::PS_W-1:0]       push_ps,
    input  logic                           queue_full
);

    logic [mbd_pkg::CNT_W-1:0] out_width_reg, out_width_next;
    logic [mbd_pkg::CNT_W-1:0] out_height_reg, out_height_next;
    logic [mbd_pkg::CNT_W-1:0] col_count_reg, col_count_next;
    logic [mbd_pkg::CNT_W-1:0] row_count_reg, row_count_next;
    logic [mbd_pkg::PIX_W-1:0] held_pixel_reg, held_pixel_next;
    logic                      col_phase_reg, col_phase_next;
    logic                      row_phase_reg, row_phase_next;

    logic [mbd_pkg::CNT_W-1:0] eff_w;
    logic [mbd_pkg::CNT_W-1:0] eff_h;
    logic                      accept;
    logic                      col_last;
    logic                      row_last;

    always_comb begin
        eff_w = out_width_reg;
        if (eff_w == '0) begin
            eff_w = mbd_pkg::CNT_W'(1);
        end
        if (int'(eff_w) > MaxOutWidth) begin
            eff_w = mbd_pkg::CNT_W'(MaxOutWidth);
        end
        eff_h = (out_height_reg == '0) ? mbd_pkg::CNT_W'(1) : out_height_reg;
    end

    assign s_tready = !queue_full && !cfg_wr;
    assign accept   = s_tvalid && s_tready;
    assign col_last = ({1'b0, col_count_reg} + 12'd1) >= {1'b0, eff_w};
    assign row_last = ({1'b0, row_count_reg} + 12'd1) >= {1'b0, eff_h};

    assign push          = accept && col_phase_reg;
    assign push_ctl.op   = row_phase_reg ? mbd_pkg::OP_EMIT : mbd_pkg::OP_STORE;
    assign push_ctl.last = col_last && row_last;
    assign push_idx      = AddrW'(col_count_reg);
    assign push_ps       = mbd_pkg::pair_sums(held_pixel_reg, s_tdata);

    always_comb begin
        out_width_next  = out_width_reg;
        out_height_next = out_height_reg;
        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        held_pixel_next = held_pixel_reg;
        col_phase_next  = col_phase_reg;
        row_phase_next  = row_phase_reg;
        if (cfg_wr) begin
            if (cfg_index == mbd_pkg::REG_OUT_WIDTH) begin
                out_width_next = cfg_data;
            end
            if (cfg_index == mbd_pkg::REG_OUT_HEIGHT) begin
                out_height_next = cfg_data;
            end
            col_count_next  = '0;
            row_count_next  = '0;
            held_pixel_next = '0;
            col_phase_next  = 1'b0;
            row_phase_next  = 1'b0;
        end else if (accept) begin
            if (!col_phase_reg) begin
                held_pixel_next = s_tdata;
                col_phase_next  = 1'b1;
            end else begin
                col_phase_next = 1'b0;
                if (col_last) begin
                    col_count_next = '0;
                    if (!row_phase_reg) begin
                        row_phase_next = 1'b1;
                    end else begin
                        row_phase_next = 1'b0;
                        row_count_next = row_last ? '0 : row_count_reg + 1'b1;
                    end
                end else begin
                    col_count_next = col_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_width_reg  <= mbd_pkg::CNT_W'(1);
            out_height_reg <= mbd_pkg::CNT_W'(1);
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            held_pixel_reg <= '0;
            col_phase_reg  <= 1'b0;
            row_phase_reg  <= 1'b0;
        end else begin
            out_width_reg  <= out_width_next;
            out_height_reg <= out_height_next;
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
            held_pixel_reg <= held_pixel_next;
            col_phase_reg  <= col_phase_next;
            row_phase_reg  <= row_phase_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_count_reg < eff_w)
        else $error("column position beyond the output width");
`endif

endmodule

### src/mbd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_fifo
// Short request queue between the pixel front end and the filter back end.
// ----------------------------------------------------------------------------
module mbd_fifo #(
    parameter int Depth = mbd_pkg::FIFO_DEPTH_DEF,
    parameter int DataW = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [DataW-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [DataW-1:0] pop_data,
    output logic             empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [DataW-1:0] entries_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("request pushed into a full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("request popped from an empty queue");
`endif

endmodule

### src/mbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_back
// Keeps the line of pair sums and produces averaged pixels on odd rows.
// ----------------------------------------------------------------------------
module mbd_back #(
    parameter int MaxOutWidth = mbd_pkg::MAX_OUT_WIDTH_DEF,
    parameter int AddrW       = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      queue_empty,
    output logic                      pop,
    input  mbd_pkg::mbd_ctl_t         pop_ctl,
    input  logic [AddrW-1:0]          pop_idx,
    input  logic [mbd_pkg::PS_W-1:0]  pop_ps,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [mbd_pkg::PIX_W-1:0] m_tdata,
    output logic                      m_tlast
);

    logic [mbd_pkg::PS_W-1:0]  line_mem [MaxOutWidth];
    logic [mbd_pkg::PS_W-1:0]  above_reg;
    logic [mbd_pkg::PS_W-1:0]  s1_ps_reg;
    logic                      s1_last_reg;
    logic                      s1_valid_reg, s1_valid_next;
    logic                      out_valid_reg, out_valid_next;
    logic [mbd_pkg::PIX_W-1:0] out_pixel_reg;
    logic                      out_last_reg;
    logic                      out_free;
    logic                      s1_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign pop      = !queue_empty && s1_free;

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = s1_valid_reg;
        end
        if (s1_free) begin
            s1_valid_next = pop && (pop_ctl.op == mbd_pkg::OP_EMIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && (pop_ctl.op == mbd_pkg::OP_STORE)) begin
            line_mem[pop_idx] <= pop_ps;
        end
        if (pop) begin
            above_reg   <= line_mem[pop_idx];
            s1_ps_reg   <= pop_ps;
            s1_last_reg <= pop_ctl.last;
        end
        if (out_free && s1_valid_reg) begin
            out_pixel_reg <= mbd_pkg::quad_average(s1_ps_reg, above_reg);
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_store_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && (pop_ctl.op == mbd_pkg::OP_STORE) |=> !s1_valid_reg)
        else $error("a line store produced a result");
    a_stalled_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_ps_reg))
        else $error("pending sum lost while the output stalled");
`endif

endmodule

### src/mipmap_box_downsample_2x2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_2x2
// 2x2 box filter that turns an ARGB8888 mip level into the next smaller one.
// ----------------------------------------------------------------------------
// Throughput: one source pixel per cycle, sustained while the output is taken.
// A register write holds off the source side for the cycle of the write.
// A result passes the queue, the line buffer read and the output register
// after the edge that accepts the bottom-right pixel of its square.
// Reset: aresetn clears counters, queue and output valid; the line buffer is
// not cleared, since an odd row reads only entries its even row has written.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_2x2 #(
    parameter int MaxOutWidth = mbd_pkg::MAX_OUT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbd_pkg::CNT_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mbd_pkg::PIX_W-1:0]     s_tdata,   // [31:0] src_pixel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mbd_pkg::PIX_W-1:0]     m_tdata,   // [31:0] dst_pixel
    output logic                          m_tlast
);

    localparam int AddrW = (MaxOutWidth > 1) ? $clog2(MaxOutWidth) : 1;
    localparam int ReqW  = $bits(mbd_pkg::mbd_ctl_t) + AddrW + mbd_pkg::PS_W;

    logic                     cfg_wr;
    logic                     push;
    mbd_pkg::mbd_ctl_t        push_ctl;
    logic [AddrW-1:0]         push_idx;
    logic [mbd_pkg::PS_W-1:0] push_ps;
    logic                     queue_full;
    logic                     queue_empty;
    logic                     pop;
    logic [ReqW-1:0]          pop_data;
    mbd_pkg::mbd_ctl_t        pop_ctl;
    logic [AddrW-1:0]         pop_idx;
    logic [mbd_pkg::PS_W-1:0] pop_ps;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    mbd_front #(
        .MaxOutWidth (MaxOutWidth),
        .AddrW       (AddrW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr     (cfg_wr),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_ctl   (push_ctl),
        .push_idx   (push_idx),
        .push_ps    (push_ps),
        .queue_full (queue_full)
    );

    mbd_fifo #(
        .Depth (mbd_pkg::FIFO_DEPTH_DEF),
        .DataW (ReqW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_ctl, push_idx, push_ps}),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    assign {pop_ctl, pop_idx, pop_ps} = pop_data;

    mbd_back #(
        .MaxOutWidth (MaxOutWidth),
        .AddrW       (AddrW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .pop         (pop),
        .pop_ctl     (pop_ctl),
        .pop_idx     (pop_idx),
        .pop_ps      (pop_ps),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
